// ----- src/ssrch_pkg.sv -----
// Shared types, constants and register codes for the substring search block.
`default_nettype none
package ssrch_pkg;

  localparam int DATA_W          = 8;
  localparam int PAT_BYTES       = 16;
  localparam int PAT_IDX_W       = 4;
  localparam int LEN_W           = 5;
  localparam int OFFSET_W        = 10;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int REG_IDX_LSB     = 3;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_MAX_BUFFER  = 1024;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_PATTERN_LENGTH,
    REG_SEARCH_FROM_END
  } ssrch_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } ssrch_in_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                length_overflow;
  } ssrch_out_t;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;
    logic active;
  } ssrch_cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/substring_search_top.sv -----
// Top level of the streaming substring search with its register port.
// One buffer byte is taken per request, one per clock cycle sustained. The
// row of MAX_PATTERN window cells compares the pattern at the newest
// position in the same cycle the byte enters, so the rate is set by that
// cell row and nothing iterates. A last byte gives one result in the next cycle
// through an output register; only a last byte meeting a result that is
// still waiting is held off. Bytes after MAX_BUFFER are dropped and flagged.
// No clearing pass after reset. Registers: pattern_low at 0x00,
// pattern_high at 0x08, pattern_length at 0x10, search_from_end at 0x18;
// write them only while no buffer is in progress.
`default_nettype none
module substring_search_top
  import ssrch_pkg::*;
#(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int MAX_BUFFER  = DEF_MAX_BUFFER
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ssrch_in_t             in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ssrch_out_t                 out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CNT_W = $clog2(MAX_BUFFER + 1);
  localparam int DW    = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_low_r;
  logic [CFG_DATA_W-1:0] pattern_high_r;
  logic [LEN_W-1:0]      pattern_length_r;
  logic                  search_from_end_r;

  // per-buffer state
  logic [CNT_W-1:0]    count_r,      count_nxt;
  logic                match_seen_r, match_seen_nxt;
  logic [OFFSET_W-1:0] match_pos_r,  match_pos_nxt;
  logic                overflow_r,   overflow_nxt;

  logic                out_valid_r,  out_valid_nxt;
  ssrch_out_t          out_data_r,   out_data_nxt;

  logic       cfg_wr;
  ssrch_reg_t cfg_idx;
  logic       in_fire;
  logic       in_room;
  logic       len_ok;
  logic       hit;
  logic       take;
  logic [DW-1:0] count_inc;
  logic [DW-1:0] offset_full;
  logic [PAT_BYTES*DATA_W-1:0] pattern_all;

  logic [DATA_W-1:0] cell_byte [MAX_PATTERN+1];
  logic              cell_hit  [MAX_PATTERN+1];

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = ssrch_reg_t'(cfg_paddr[CFG_ADDR_W-1:REG_IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r     <= '0;
      pattern_high_r    <= '0;
      pattern_length_r  <= '0;
      search_from_end_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_LOW:     pattern_low_r     <= cfg_pwdata;
        REG_PATTERN_HIGH:    pattern_high_r    <= cfg_pwdata;
        REG_PATTERN_LENGTH:  pattern_length_r  <= cfg_pwdata[LEN_W-1:0];
        REG_SEARCH_FROM_END: search_from_end_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_LOW:     cfg_prdata = pattern_low_r;
      REG_PATTERN_HIGH:    cfg_prdata = pattern_high_r;
      REG_PATTERN_LENGTH:  cfg_prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pattern_length_r};
      REG_SEARCH_FROM_END: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, search_from_end_r};
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- cell row ----------------
  assign pattern_all  = {pattern_high_r, pattern_low_r};
  assign in_fire      = in_valid && in_ready;
  assign in_room      = count_r < CNT_W'(MAX_BUFFER);
  assign cell_byte[0] = in_data.data_byte;
  assign cell_hit[0]  = 1'b1;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    ssrch_cell_ctl_t      ctl;
    logic [LEN_W-1:0]     exp_k;
    logic [DATA_W-1:0]    exp_byte;

    // cell i (i-th newest byte) lines up with pattern byte len-1-i
    assign exp_k      = pattern_length_r - LEN_W'(1) - LEN_W'(i);
    assign exp_byte   = pattern_all[exp_k[PAT_IDX_W-1:0]*DATA_W +: DATA_W];
    assign ctl.shift  = in_fire && in_room;
    assign ctl.active = LEN_W'(i) < pattern_length_r;

    ssrch_cell u_cell (
      .clk    (clk),
      .ctl_i  (ctl),
      .byte_i (cell_byte[i]),
      .exp_i  (exp_byte),
      .hit_i  (cell_hit[i]),
      .byte_o (cell_byte[i+1]),
      .hit_o  (cell_hit[i+1])
    );
  end

  // ---------------- match tracking ----------------
  assign count_inc   = DW'(count_r) + DW'(1);
  assign offset_full = count_inc - DW'(pattern_length_r);
  assign len_ok      = (pattern_length_r != '0)
                    && (pattern_length_r <= LEN_W'(MAX_PATTERN))
                    && (count_inc >= DW'(pattern_length_r));
  assign hit         = in_room && len_ok && cell_hit[MAX_PATTERN];
  assign take        = hit && (search_from_end_r || !match_seen_r);

  // a last byte may enter unless the previous result is still stuck
  assign in_ready = !out_valid_r || out_ready || !in_data.last_byte;

  always_comb begin
    count_nxt      = count_r;
    match_seen_nxt = match_seen_r;
    match_pos_nxt  = match_pos_r;
    overflow_nxt   = overflow_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    if (in_fire) begin
      if (in_room) begin
        count_nxt = count_inc[CNT_W-1:0];
      end
      if (take) begin
        match_seen_nxt = 1'b1;
        match_pos_nxt  = offset_full[OFFSET_W-1:0];
      end
      if (!in_room) begin
        overflow_nxt = 1'b1;
      end
      if (in_data.last_byte) begin
        out_valid_nxt                = 1'b1;
        out_data_nxt.found           = match_seen_nxt;
        out_data_nxt.match_offset    = match_seen_nxt ? match_pos_nxt : '0;
        out_data_nxt.length_overflow = overflow_nxt;
        count_nxt      = '0;
        match_seen_nxt = 1'b0;
        match_pos_nxt  = '0;
        overflow_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      match_seen_r <= 1'b0;
      match_pos_r  <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      match_seen_r <= match_seen_nxt;
      match_pos_r  <= match_pos_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> out_valid_r)
    else $error("last byte did not produce a result");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_byte |=> (count_r == '0) && !match_seen_r && !overflow_r)
    else $error("buffer state not cleared after last byte");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BUFFER))
    else $error("byte count past buffer limit");

  a_first_match_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.last_byte && !search_from_end_r && match_seen_r
      |=> $stable(match_pos_r))
    else $error("first match position overwritten");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.match_offset == '0)
    else $error("offset nonzero without a match");

endmodule
`default_nettype wire

// ----- src/ssrch_cell.sv -----
// One window cell: holds a byte, passes it on, and extends the match chain.
`default_nettype none
module ssrch_cell
  import ssrch_pkg::*;
(
  input  wire logic              clk,
  input  wire ssrch_cell_ctl_t   ctl_i,
  input  wire logic [DATA_W-1:0] byte_i,
  input  wire logic [DATA_W-1:0] exp_i,
  input  wire logic              hit_i,
  output logic      [DATA_W-1:0] byte_o,
  output logic                   hit_o
);

  logic [DATA_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (ctl_i.shift) begin
      byte_r <= byte_i;
    end
  end

  // compare against the byte this cell holds after the shift
  assign hit_o  = hit_i && (!ctl_i.active || (byte_i == exp_i));
  assign byte_o = byte_r;

endmodule
`default_nettype wire

// ----- tb/sv/substring_search_top_test.sv -----
// Self-checking testbench for the streaming substring search block.
`timescale 1ns / 1ps
module substring_search_top_test;
  import ssrch_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_PAD      = 4;
  localparam int RANDOM_BYTES   = 400;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  ssrch_in_t             in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  ssrch_out_t            out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  substring_search_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register shadows
  logic [127:0] pattern_bits = '0;
  int           pat_len      = 0;
  logic         from_end     = 1'b0;

  // per-buffer search state
  logic [7:0]   recent_bytes [PAT_BYTES];
  int           bytes_taken  = 0;
  logic         hit_seen     = 1'b0;
  int           hit_offset   = 0;
  logic         dropped_seen = 1'b0;

  ssrch_out_t   pending_results [$];

  int unsigned  send_idle_pct = 29;
  int unsigned  recv_idle_pct = 88;
  int           errors        = 0;
  int           bytes_sent    = 0;
  int           buffers_sent  = 0;
  int           results_seen  = 0;
  int           matches_seen  = 0;
  int           overflows     = 0;
  int           stall_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [7:0] pattern_byte(int k);
    return pattern_bits[8*k +: 8];
  endfunction

  function automatic void clear_search();
    foreach (recent_bytes[i]) recent_bytes[i] = 8'h00;
    bytes_taken  = 0;
    hit_seen     = 1'b0;
    hit_offset   = 0;
    dropped_seen = 1'b0;
  endfunction

  // advance the search state by one accepted byte; a last byte yields a result
  function automatic void predict_byte(logic [7:0] b, logic lst);
    ssrch_out_t res;
    logic       hit;
    int         i;
    hit = 1'b0;
    if (bytes_taken < DEF_MAX_BUFFER) begin
      for (i = PAT_BYTES - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
      recent_bytes[0] = b;
      bytes_taken++;
      if (pat_len != 0 && pat_len <= PAT_BYTES && bytes_taken >= pat_len) begin
        hit = 1'b1;
        for (i = 0; i < pat_len; i++)
          if (recent_bytes[pat_len-1-i] != pattern_byte(i)) hit = 1'b0;
      end
      if (hit && (from_end || !hit_seen)) begin
        hit_seen   = 1'b1;
        hit_offset = bytes_taken - pat_len;
      end
    end else begin
      dropped_seen = 1'b1;
    end
    if (lst) begin
      res.found           = hit_seen;
      res.match_offset    = hit_seen ? OFFSET_W'(hit_offset) : '0;
      res.length_overflow = dropped_seen;
      pending_results.push_back(res);
      clear_search();
    end
  endfunction

  // result checker; samples mid-cycle, the handshake completes at the next edge
  always @(negedge clk) begin
    ssrch_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found=%0b offset=%0d overflow=%0b",
                   out_data.found, out_data.match_offset, out_data.length_overflow);
      end else begin
        want = pending_results.pop_front();
        matches_seen += want.found;
        overflows    += want.length_overflow;
        if (out_data.found !== want.found ||
            out_data.match_offset !== want.match_offset ||
            out_data.length_overflow !== want.length_overflow) begin
          errors++;
          if (errors <= 10) begin
            $write("result %0d mismatch: want found=%0b offset=%0d overflow=%0b,",
                   results_seen, want.found, want.match_offset, want.length_overflow);
            $display(" got found=%0b offset=%0d overflow=%0b",
                     out_data.found, out_data.match_offset, out_data.length_overflow);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_results.size());
        $display("substring_search_top_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predict_byte(b, lst);
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic send_buffer(input logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
    buffers_sent++;
  endtask

  // hold requests until every result is back, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input ssrch_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx) << REG_IDX_LSB;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:     pattern_bits[63:0]   = value;
      REG_PATTERN_HIGH:    pattern_bits[127:64] = value;
      REG_PATTERN_LENGTH:  pat_len  = int'(value[LEN_W-1:0]);
      REG_SEARCH_FROM_END: from_end = value[0];
      default: ;
    endcase
  endtask

  task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] len_word, input logic [63:0] dir_word);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, len_word);
    write_reg(REG_SEARCH_FROM_END, dir_word);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // registers still at reset: zero length never matches, even on a zero window
  task automatic test_reset_registers();
    send_buffer('{8'h00, 8'h00});
    send_buffer('{8'h00});
  endtask

  task automatic test_first_and_last_match();
    wait_idle();
    program_search(64'h6261, 64'h0, 64'd2, 64'd0);
    send_buffer('{8'h61, 8'h62, 8'h61, 8'h62});
    wait_idle();
    // last-match mode must also take the match ending on the final byte
    program_search(64'h6261, 64'h0, 64'd2, 64'd1);
    send_buffer('{8'h61, 8'h62, 8'h61, 8'h62});
  endtask

  task automatic test_pattern_extremes();
    logic [7:0] bytes_q[$];
    int k;
    for (k = 0; k < PAT_BYTES; k++) bytes_q.push_back((k % 2) ? 8'hFF : 8'h00);
    wait_idle();
    program_search(64'hFF00FF00FF00FF00, 64'hFF00FF00FF00FF00, 64'd16, 64'd0);
    send_buffer(bytes_q);
    wait_idle();
    // pattern longer than the buffer
    program_search(64'hFF00FF00FF00FF00, 64'h0, 64'd5, 64'd1);
    send_buffer(bytes_q[0:3]);
    wait_idle();
    // lengths past the pattern store, upper write bits set
    program_search(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFF1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_buffer('{8'h00, 8'hFF});
    wait_idle();
    program_search(64'h0, 64'h0, '1, '1);
    send_buffer('{8'h00});
  endtask

  // one over-long buffer: match at the highest offset, dropped bytes including the last
  task automatic test_buffer_overflow();
    logic [7:0] bytes_q[$];
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < DEF_MAX_BUFFER + 2; k++) bytes_q.push_back(8'h00);
    bytes_q[DEF_MAX_BUFFER-1] = 8'h5A;
    bytes_q[DEF_MAX_BUFFER]   = 8'h5A;
    bytes_q[DEF_MAX_BUFFER+1] = 8'h5A;
    wait_idle();
    program_search(64'h5A, 64'h0, 64'd1, 64'd1);
    send_buffer(bytes_q);
  endtask

  task automatic randomize_search();
    logic [127:0] pat;
    logic [63:0]  len_word;
    logic [63:0]  dir_word;
    logic         narrow;
    int           len;
    int           r;
    int           k;
    narrow = ($urandom_range(2) == 0);
    for (k = 0; k < PAT_BYTES; k++)
      pat[8*k +: 8] = narrow ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
    r = $urandom_range(99);
    if (r < 5)       len = 0;
    else if (r < 10) len = $urandom_range(31, 17);
    else if (r < 25) len = $urandom_range(16, 9);
    else             len = $urandom_range(8, 1);
    len_word = 64'(len);
    dir_word = 64'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      len_word = {$urandom, $urandom};
      len_word[LEN_W-1:0] = LEN_W'(len);
      dir_word[63:1] = 63'({$urandom, $urandom});
    end
    program_search(pat[63:0], pat[127:64], len_word, dir_word);
  endtask

  function automatic logic [7:0] narrow_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pattern_byte($urandom_range(PAT_BYTES - 1));
    endcase
  endfunction

  // mostly buffers seeded with copies of the pattern, some pure noise
  task automatic send_random_buffer();
    logic [7:0] bytes_q[$];
    logic       narrow;
    int         n;
    int         r;
    int         pos;
    int         k;
    int         plants;
    r = $urandom_range(99);
    n = (r < 80) ? $urandom_range(20, 1) : $urandom_range(48, 21);
    narrow = ($urandom_range(3) == 0);
    for (k = 0; k < n; k++) bytes_q.push_back(narrow ? narrow_byte() : 8'($urandom));
    if (pat_len >= 1 && pat_len <= PAT_BYTES && pat_len <= n && $urandom_range(9) < 7) begin
      plants = $urandom_range(3, 1);
      repeat (plants) begin
        pos = ($urandom_range(4) == 0) ? n - pat_len : $urandom_range(n - pat_len);
        for (k = 0; k < pat_len; k++) bytes_q[pos+k] = pattern_byte(k);
      end
    end
    send_buffer(bytes_q);
  endtask

  task automatic test_random_buffers();
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    int          target;
    int          p;
    send_pct = '{29, 88, 0};
    recv_pct = '{88, 29, 0};
    for (p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      wait_idle();
      randomize_search();
      target = bytes_sent + RANDOM_BYTES / 3;
      while (bytes_sent < target) begin
        if ($urandom_range(3) == 0) begin
          wait_idle();
          randomize_search();
        end
        send_random_buffer();
      end
    end
  endtask

  initial begin
    clear_search();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_registers();
    test_first_and_last_match();
    test_pattern_extremes();
    test_buffer_overflow();
    test_random_buffers();
    wait_idle();
    errors += pending_results.size();
    $display("covered %0d buffers / %0d bytes, %0d results checked", buffers_sent, bytes_sent,
             results_seen);
    $display("  %0d with a match, %0d with dropped bytes, %0d failures", matches_seen, overflows,
             errors);
    if (errors == 0)
      $display("substring_search_top_test: done, clean");
    else
      $display("substring_search_top_test: done, errors");
    $finish;
  end

endmodule
